FILE: rtl/core/lkvc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lkvc_pkg: shared types and constants of the LRU key-value cache
// Entry count, field widths, request action codes and payload structs.
// ---------------------------------------------------------------------------
package lkvc_pkg;

   localparam int ENTRIES    = 8;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int IDX_BITS   = $clog2(ENTRIES);
   localparam int RANK_BITS  = IDX_BITS;
   localparam int OCC_BITS   = $clog2(ENTRIES + 1);
   localparam int CAP_BITS   = 4;

   typedef logic [KEY_BITS-1:0]   key_type;
   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [IDX_BITS-1:0]   idx_type;
   typedef logic [RANK_BITS-1:0]  rank_type;
   typedef logic [OCC_BITS-1:0]   occ_type;
   typedef logic [CAP_BITS-1:0]   cap_type;

   localparam cap_type CAP_RESET = CAP_BITS'(3);

   typedef enum logic [1:0] {
      ACT_LOOKUP = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_REMOVE = 2'd2,
      ACT_PROBE  = 2'd3
   } action_type;

   typedef struct packed {
      action_type action;
      key_type    key;
      value_type  value;
   } req_type;

   typedef struct packed {
      logic      hit;
      value_type read_value;
      logic      evicted;
      key_type   evicted_key;
   } rsp_type;

endpackage : lkvc_pkg
`default_nettype wire

FILE: rtl/core/lkvc_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lkvc_if: request and response channels of the LRU key-value cache
// Valid/ready channels; a transfer happens when valid and ready are high.
// ---------------------------------------------------------------------------
interface lkvc_req_if import lkvc_pkg::*;;
   logic       valid;
   logic       ready;
   action_type action;
   key_type    key;
   value_type  value;

   modport source (output valid, action, key, value, input ready);
   modport sink   (input valid, action, key, value, output ready);
endinterface : lkvc_req_if

interface lkvc_rsp_if import lkvc_pkg::*;;
   logic      valid;
   logic      ready;
   logic      hit;
   value_type read_value;
   logic      evicted;
   key_type   evicted_key;

   modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
   modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface : lkvc_rsp_if
`default_nettype wire

FILE: rtl/core/lkvc_store.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lkvc_store: entry array with parallel key match and recency ranks
// Holds keys, values, valid bits, ranks and occupancy; applies one request
// per cycle when cmd_fire is high and returns its result combinationally.
// ---------------------------------------------------------------------------
module lkvc_store import lkvc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_fire,
   input  wire req_type cmd,
   input  wire occ_type eff_cap,
   output rsp_type      result
);

   logic [ENTRIES-1:0] valid_ff, valid_in;
   key_type            key_ff   [ENTRIES];
   key_type            key_in   [ENTRIES];
   value_type          value_ff [ENTRIES];
   value_type          value_in [ENTRIES];
   rank_type           rank_ff  [ENTRIES];
   rank_type           rank_in  [ENTRIES];
   occ_type            occ_ff, occ_in;

   logic [ENTRIES-1:0] match;
   logic               hit;
   idx_type            hit_idx;
   logic               lru_any;
   idx_type            lru_idx;
   logic               free_any;
   idx_type            free_idx;

   // recency operations selected for this request
   logic     do_touch;    // make tgt_idx most recent
   logic     do_drop;     // invalidate tgt_idx, close the rank gap
   logic     do_age;      // new entry at free_idx, all others age
   idx_type  tgt_idx;
   rank_type tgt_rank;

   // parallel compare and priority picks (lowest slot wins)
   always_comb begin
      hit_idx  = '0;
      lru_idx  = '0;
      free_idx = '0;
      lru_any  = 1'b0;
      free_any = 1'b0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         match[i] = valid_ff[i] && (key_ff[i] == cmd.key);
         if (match[i]) begin
            hit_idx = IDX_BITS'(i);
         end
         // ranks of valid entries are always 0 .. occupancy-1
         if (valid_ff[i] && ({1'b0, rank_ff[i]} == occ_ff - OCC_BITS'(1))) begin
            lru_idx = IDX_BITS'(i);
            lru_any = 1'b1;
         end
         if (!valid_ff[i]) begin
            free_idx = IDX_BITS'(i);
            free_any = 1'b1;
         end
      end
      hit = |match;
   end

   // request decode
   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      occ_in   = occ_ff;
      do_touch = 1'b0;
      do_drop  = 1'b0;
      do_age   = 1'b0;
      tgt_idx  = hit_idx;
      result   = '0;
      result.hit = hit;
      if (cmd_fire) begin
         unique case (cmd.action)
            ACT_LOOKUP: begin
               if (hit) begin
                  result.read_value = value_ff[hit_idx];
                  do_touch = 1'b1;
               end
            end
            ACT_INSERT: begin
               if (hit) begin
                  value_in[hit_idx] = cmd.value;
                  do_touch = 1'b1;
               end else if ((occ_ff >= eff_cap) && lru_any) begin
                  // evict and reuse: same rank shift as touching the victim
                  result.evicted     = 1'b1;
                  result.evicted_key = key_ff[lru_idx];
                  key_in[lru_idx]    = cmd.key;
                  value_in[lru_idx]  = cmd.value;
                  tgt_idx  = lru_idx;
                  do_touch = 1'b1;
               end else if (free_any) begin
                  valid_in[free_idx] = 1'b1;
                  key_in[free_idx]   = cmd.key;
                  value_in[free_idx] = cmd.value;
                  occ_in = occ_ff + OCC_BITS'(1);
                  do_age = 1'b1;
               end
            end
            ACT_REMOVE: begin
               if (hit) begin
                  valid_in[hit_idx] = 1'b0;
                  do_drop = 1'b1;
                  if (occ_ff != '0) begin
                     occ_in = occ_ff - OCC_BITS'(1);
                  end
               end
            end
            ACT_PROBE: begin
            end
            default: begin
            end
         endcase
      end
   end

   // rank update
   always_comb begin
      tgt_rank = rank_ff[tgt_idx];
      rank_in  = rank_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         if (valid_ff[i] && (IDX_BITS'(i) != tgt_idx)) begin
            if (do_touch && (rank_ff[i] < tgt_rank)) begin
               rank_in[i] = rank_ff[i] + RANK_BITS'(1);
            end
            if (do_drop && (rank_ff[i] > tgt_rank)) begin
               rank_in[i] = rank_ff[i] - RANK_BITS'(1);
            end
         end
         if (do_age && valid_ff[i]) begin
            rank_in[i] = rank_ff[i] + RANK_BITS'(1);
         end
      end
      if (do_touch || do_drop) begin
         rank_in[tgt_idx] = '0;
      end
      if (do_age) begin
         rank_in[free_idx] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
         rank_ff  <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

endmodule : lkvc_store
`default_nettype wire

FILE: rtl/core/lru_key_value_cache_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lru_key_value_cache_unit: fully associative key-value cache, LRU eviction
// Top level: request register, capacity register, store and response
// register with valid/ready handshakes on both sides.
// ---------------------------------------------------------------------------
// Eight-entry fully associative cache of 32-bit keys and 32-bit values.
// Each request transfer carries an action (lookup, insert, remove, probe),
// a key and a value; each produces exactly one response transfer, in order.
// Throughput is one request per clock while responses drain without
// back-pressure: the request is captured in an input register, all entries
// are compared with its key once the output register is free or draining,
// and at the end of that cycle the entry state and recency ranks are
// updated while the response lands in an output register that drives
// response valid. The output register is the only place a
// response waits; while it is held the input register keeps one more
// request and req ready drops. Capacity (csr_wr_data, 4 bits, reset 3) is
// the occupancy at which an insert miss evicts the least recent entry;
// zero acts as one and values above eight act as eight. Write it only while
// the cache is idle; lowering it while entries are held keeps them, and
// each later insert miss then evicts one. No clearing pass is needed after
// reset: valid bits clear at once.
// ---------------------------------------------------------------------------
module lru_key_value_cache_unit import lkvc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    csr_wr_en,
   input  wire cap_type csr_wr_data,
   lkvc_req_if.sink     req_ch,
   lkvc_rsp_if.source   rsp_ch
);

   cap_type cap_ff;
   occ_type eff_cap;

   logic    in_valid_ff, in_valid_in;
   req_type in_req_ff, in_req_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic    advance;   // response slot free or being drained this cycle
   logic    fire;      // held request is processed this cycle
   rsp_type store_rsp;

   // capacity clamp: 0 -> 1, above ENTRIES -> ENTRIES
   always_comb begin
      priority if (cap_ff == '0) begin
         eff_cap = OCC_BITS'(1);
      end else if ({{(32-CAP_BITS){1'b0}}, cap_ff} > 32'(ENTRIES)) begin
         eff_cap = OCC_BITS'(ENTRIES);
      end else begin
         eff_cap = OCC_BITS'(cap_ff);
      end
   end

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign fire         = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_req_in   = in_req_ff;
      if (req_ch.ready) begin
         in_valid_in      = req_ch.valid;
         in_req_in.action = req_ch.action;
         in_req_in.key    = req_ch.key;
         in_req_in.value  = req_ch.value;
      end
   end

   lkvc_store u_store (
      .clock    (clock),
      .reset    (reset),
      .cmd_fire (fire),
      .cmd      (in_req_ff),
      .eff_cap  (eff_cap),
      .result   (store_rsp)
   );

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = store_rsp;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= CAP_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_req_ff   <= in_req_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.hit         = rsp_data_ff.hit;
   assign rsp_ch.read_value  = rsp_data_ff.read_value;
   assign rsp_ch.evicted     = rsp_data_ff.evicted;
   assign rsp_ch.evicted_key = rsp_data_ff.evicted_key;

endmodule : lru_key_value_cache_unit
`default_nettype wire

FILE: rtl/core/lkvc_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lkvc_checker: port-level assertions for the LRU key-value cache
// Watches the response channel; bound to the top level below.
// ---------------------------------------------------------------------------
module lkvc_checker import lkvc_pkg::*; (
   input wire logic      clock,
   input wire logic      reset,
   input wire logic      rsp_valid,
   input wire logic      rsp_ready,
   input wire logic      rsp_hit,
   input wire value_type rsp_read_value,
   input wire logic      rsp_evicted,
   input wire key_type   rsp_evicted_key
);

   // no response comes out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a pending response transfer is not withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   // eviction only on an insert miss
   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> !rsp_hit && (rsp_read_value == '0))
      else $error("eviction reported with hit or read data");

   // evicted key is zero unless an entry was pushed out
   a_evict_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted |-> (rsp_evicted_key == '0))
      else $error("evicted key without eviction");

   // read data only on a hit
   a_read_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> (rsp_read_value == '0))
      else $error("read data on a miss");

endmodule : lkvc_checker

bind lru_key_value_cache_unit lkvc_checker u_lkvc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_hit         (rsp_ch.hit),
   .rsp_read_value  (rsp_ch.read_value),
   .rsp_evicted     (rsp_ch.evicted),
   .rsp_evicted_key (rsp_ch.evicted_key)
);
`default_nettype wire
